/* rtl/core/ntc_pkg.sv */
// Shared types, constants and codes for the NTC thermistor linearizer.
// No dependencies; compiled first.
package ntc_pkg;

   // Port widths
   localparam int DEF_ADC_BITS = 12;
   localparam int TEMP_W       = 18;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 20;

   // Register widths
   localparam int RF_W = 20;
   localparam int VS_W = 13;
   localparam int B_W  = 14;
   localparam int RN_W = 20;
   localparam int T0_W = 16;

   // Register reset values
   localparam logic [RF_W-1:0] RF_RESET = RF_W'(10000);
   localparam logic [VS_W-1:0] VS_RESET = VS_W'(3300);
   localparam logic [B_W-1:0]  B_RESET  = B_W'(3950);
   localparam logic [RN_W-1:0] RN_RESET = RN_W'(10000);
   localparam logic [T0_W-1:0] T0_RESET = T0_W'(29815);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIXED_RES   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SUPPLY_MV   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BETA        = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL_RES = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL_T   = CSR_IDX_W'(4);

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_ZERO_CODE = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_AT_SUPPLY = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_SATURATED = STATUS_W'(3);

   // Arithmetic constants
   localparam int FULL_SCALE_MV = 1100;
   localparam int CK_OFFSET     = 27315;
   localparam int TEMP_MAX      = 100000;
   localparam int TEMP_MIN      = -27315;
   localparam int LN2_Q24       = 11629080;
   localparam int LN_SHIFT      = 24;
   localparam int INV_SHIFT     = 40;
   localparam int TERM_SHIFT    = 10;
   localparam int FRAC_BITS     = 30;
   localparam int CENTI         = 100;
   localparam int DIVW          = 21;   // holds 100 * beta and T0

   // Pipeline control handed to the arithmetic units
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   // Per-item flags that ride along the pipeline
   typedef struct packed {
      logic zero_code;
      logic at_supply;
      logic neg;
      logic nonpos;
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

endpackage

/* rtl/core/ntc_log2_pipe.sv */
// Pipelined base-2 logarithm, unsigned Q.30, over NL lanes with a sideband.
// Depends on ntc_pkg. Stages: leading one search, normalize, then FRAC_BITS squaring stages.
module ntc_log2_pipe import ntc_pkg::*; #(
   parameter int NL = 2,
   parameter int XW = 45,
   parameter int LW = 36,
   parameter int SW = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pipe_ctl_type               ctl,
   input  logic [NL-1:0][XW-1:0]      in_x,
   input  logic [SW-1:0]              in_side,
   output logic                       out_valid,
   output logic [NL-1:0][LW-1:0]      out_log,
   output logic [SW-1:0]              out_side
);

   localparam int KW = LW - FRAC_BITS;
   localparam int MW = FRAC_BITS + 1;

   // index of the top set bit, zero for a zero word
   function automatic logic [KW-1:0] lead_one(input logic [XW-1:0] x);
      logic [KW-1:0] k;
      k = '0;
      for (int i = 0; i < XW; i++) begin
         if (x[i]) k = KW'(i);
      end
      return k;
   endfunction

   // stage: leading one search
   logic                    v0_ff;
   logic [NL-1:0][XW-1:0]   x0_ff;
   logic [NL-1:0][KW-1:0]   k0_ff;
   logic [SW-1:0]           side0_ff;

   // stage: normalize mantissa to Q1.30
   logic                    v1_ff;
   logic [NL-1:0][MW-1:0]   m1_ff;
   logic [NL-1:0][KW-1:0]   k1_ff;
   logic [SW-1:0]           side1_ff;
   logic [NL-1:0][MW-1:0]   m1_in;

   // squaring stages
   logic                    vs_ff    [FRAC_BITS];
   logic [NL-1:0][MW-1:0]   ms_ff    [FRAC_BITS];
   logic [NL-1:0][FRAC_BITS-1:0] fs_ff [FRAC_BITS];
   logic [NL-1:0][KW-1:0]   ks_ff    [FRAC_BITS];
   logic [SW-1:0]           sides_ff [FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (ctl.en) begin
         v0_ff <= ctl.valid;
         v1_ff <= v0_ff;
      end
   end

   genvar l, s;
   for (l = 0; l < NL; l++) begin : g_norm
      logic [KW-1:0] shl;
      logic [XW-1:0] y;
      assign shl      = KW'(XW - 1) - k0_ff[l];
      assign y        = x0_ff[l] << shl;
      assign m1_in[l] = y[XW-1 -: MW];
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         for (int i = 0; i < NL; i++) begin
            x0_ff[i] <= in_x[i];
            k0_ff[i] <= lead_one(in_x[i]);
         end
         side0_ff <= in_side;
         m1_ff    <= m1_in;
         k1_ff    <= k0_ff;
         side1_ff <= side0_ff;
      end
   end

   for (s = 0; s < FRAC_BITS; s++) begin : g_sq
      logic                         v_src;
      logic [NL-1:0][MW-1:0]        m_src;
      logic [NL-1:0][FRAC_BITS-1:0] f_src;
      logic [NL-1:0][KW-1:0]        k_src;
      logic [SW-1:0]                side_src;
      logic [NL-1:0][MW-1:0]        m_in;
      logic [NL-1:0][FRAC_BITS-1:0] f_in;

      if (s == 0) begin : g_first
         assign v_src    = v1_ff;
         assign m_src    = m1_ff;
         assign f_src    = '0;
         assign k_src    = k1_ff;
         assign side_src = side1_ff;
      end else begin : g_next
         assign v_src    = vs_ff[s-1];
         assign m_src    = ms_ff[s-1];
         assign f_src    = fs_ff[s-1];
         assign k_src    = ks_ff[s-1];
         assign side_src = sides_ff[s-1];
      end

      // square, take the next fraction bit, renormalize
      for (l = 0; l < NL; l++) begin : g_lane
         logic [2*MW-1:0] sq;
         logic [MW:0]     t;
         assign sq      = (2*MW)'(m_src[l]) * (2*MW)'(m_src[l]);
         assign t       = sq[2*MW-1:FRAC_BITS];
         assign m_in[l] = t[MW] ? t[MW:1] : t[MW-1:0];
         assign f_in[l] = {f_src[l][FRAC_BITS-2:0], t[MW]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[s] <= 1'b0;
         end else if (ctl.en) begin
            vs_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            ms_ff[s]    <= m_in;
            fs_ff[s]    <= f_in;
            ks_ff[s]    <= k_src;
            sides_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vs_ff[FRAC_BITS-1];
   assign out_side  = sides_ff[FRAC_BITS-1];
   for (l = 0; l < NL; l++) begin : g_out
      assign out_log[l] = {ks_ff[FRAC_BITS-1][l], fs_ff[FRAC_BITS-1][l]};
   end

endmodule

/* rtl/core/ntc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, NL lanes plus a sideband.
// Depends on ntc_pkg. The pipeline has NW stages.
module ntc_div_pipe import ntc_pkg::*; #(
   parameter int NL = 1,
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int SW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipe_ctl_type           ctl,
   input  logic [NL-1:0][NW-1:0]  in_num,
   input  logic [NL-1:0][DW-1:0]  in_den,
   input  logic [SW-1:0]          in_side,
   output logic                   out_valid,
   output logic [NL-1:0][NW-1:0]  out_quo,
   output logic [SW-1:0]          out_side
);

   logic                  vld_ff  [NW];
   logic [NL-1:0][DW-1:0] rem_ff  [NW];
   logic [NL-1:0][DW-1:0] den_ff  [NW];
   logic [NL-1:0][NW-1:0] qn_ff   [NW];   // dividend bits shift out, quotient bits in
   logic [SW-1:0]         side_ff [NW];

   genvar s, l;
   for (s = 0; s < NW; s++) begin : g_stage
      logic                  v_src;
      logic [NL-1:0][DW-1:0] rem_src;
      logic [NL-1:0][DW-1:0] den_src;
      logic [NL-1:0][NW-1:0] qn_src;
      logic [SW-1:0]         side_src;
      logic [NL-1:0][DW-1:0] rem_in;
      logic [NL-1:0][NW-1:0] qn_in;

      if (s == 0) begin : g_first
         assign v_src    = ctl.valid;
         assign rem_src  = '0;
         assign den_src  = in_den;
         assign qn_src   = in_num;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign qn_src   = qn_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // trial subtract of the divisor from the shifted partial remainder
      for (l = 0; l < NL; l++) begin : g_lane
         logic [DW:0] trial;
         logic        take;
         assign trial     = {rem_src[l], qn_src[l][NW-1]};
         assign take      = trial >= {1'b0, den_src[l]};
         assign rem_in[l] = take ? DW'(trial - {1'b0, den_src[l]}) : trial[DW-1:0];
         assign qn_in[l]  = {qn_src[l][NW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ctl.en) begin
            vld_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            qn_ff[s]   <= qn_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = qn_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

/* rtl/core/ntc_thermistor_linearizer.sv */
// Top level: NTC thermistor linearizer, ADC code to centi-degrees Celsius (beta form).
// Depends on ntc_pkg, ntc_log2_pipe and ntc_div_pipe.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_adc_code
//   rsp     | out       | rsp_valid / rsp_ready | rsp_temp_centi_celsius, rsp_status
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One item enters per cycle while the pipeline advances. The first divider is TW =
// clog2(ADC_BITS+33)+41 bits wide and the final one FW = TW+2 bits; the two restoring
// dividers, one stage per quotient bit, and the 30 squaring stages of the logarithm make up most of the stages.
// The whole pipeline advances together; it holds when a result waits and rsp_ready is low.
// Synchronous reset clears valid bits and loads register defaults; csr is always ready.
module ntc_thermistor_linearizer import ntc_pkg::*; #(
   parameter int ADC_BITS = DEF_ADC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ADC_BITS-1:0]        req_adc_code,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TEMP_W-1:0]   rsp_temp_centi_celsius,
   output logic [STATUS_W-1:0]        rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = ADC_BITS + VS_W;               // millivolt products
   localparam int XW = PW + RF_W;                     // ratio numerator / denominator
   localparam int LW = $clog2(XW) + FRAC_BITS;        // log2 Q.30
   localparam int TW = LW + TERM_SHIFT + 1;           // first divider width
   localparam int IW = TW + 2;                        // signed inverse temperature
   localparam int FW = TW + 2;                        // final divider width
   localparam logic [PW-1:0] FS = PW'((64'd1 << ADC_BITS) - 64'd1);
   localparam int LANE_A = 0;
   localparam int LANE_B = 1;
   localparam int NLOG_LANES_C = 2;

   // configuration registers
   logic [RF_W-1:0] rf_ff;
   logic [VS_W-1:0] vs_ff;
   logic [B_W-1:0]  b_ff;
   logic [RN_W-1:0] rn_ff;
   logic [T0_W-1:0] t0_ff;
   logic [RF_W-1:0] rf_nz;
   logic [VS_W-1:0] vs_nz;
   logic [B_W-1:0]  b_nz;
   logic [RN_W-1:0] rn_nz;
   logic [T0_W-1:0] t0_nz;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff <= RF_RESET;
         vs_ff <= VS_RESET;
         b_ff  <= B_RESET;
         rn_ff <= RN_RESET;
         t0_ff <= T0_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FIXED_RES:   rf_ff <= csr_wdata[RF_W-1:0];
            REG_SUPPLY_MV:   vs_ff <= csr_wdata[VS_W-1:0];
            REG_BETA:        b_ff  <= csr_wdata[B_W-1:0];
            REG_NOMINAL_RES: rn_ff <= csr_wdata[RN_W-1:0];
            REG_NOMINAL_T:   t0_ff <= csr_wdata[T0_W-1:0];
            default: ;
         endcase
      end
   end

   // a register written as zero acts as one
   assign rf_nz = (rf_ff == '0) ? RF_W'(1) : rf_ff;
   assign vs_nz = (vs_ff == '0) ? VS_W'(1) : vs_ff;
   assign b_nz  = (b_ff  == '0) ? B_W'(1)  : b_ff;
   assign rn_nz = (rn_ff == '0) ? RN_W'(1) : rn_ff;
   assign t0_nz = (t0_ff == '0) ? T0_W'(1) : t0_ff;

   // global advance: move when the output register is free or being taken
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: code to millivolt products
   logic          s1_vld_ff;
   logic [PW-1:0] s1_p_ff;
   logic [PW-1:0] s1_q_ff;
   logic          s1_zero_ff;
   // stage 2: supply compare and difference
   logic          s2_vld_ff;
   logic [PW-1:0] s2_p_ff;
   logic [PW-1:0] s2_diff_ff;
   flags_type     s2_flags_ff;
   // stage 3: resistance ratio terms
   logic          s3_vld_ff;
   logic [NLOG_LANES_C-1:0][XW-1:0] s3_x_ff;
   flags_type     s3_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff    <= PW'(FULL_SCALE_MV) * PW'(req_adc_code);
         s1_q_ff    <= PW'(vs_nz) * FS;
         s1_zero_ff <= (req_adc_code == '0);

         s2_p_ff     <= s1_p_ff;
         s2_diff_ff  <= s1_q_ff - s1_p_ff;
         s2_flags_ff <= '{zero_code: s1_zero_ff, at_supply: (s1_p_ff >= s1_q_ff),
                          neg: 1'b0, nonpos: 1'b0};

         // lane A: Rf * (Vs*FS - 1100*code), lane B: 1100*code * Rn
         s3_x_ff[LANE_A] <= XW'(rf_nz) * XW'(s2_diff_ff);
         s3_x_ff[LANE_B] <= XW'(rn_nz) * XW'(s2_p_ff);
         s3_flags_ff     <= s2_flags_ff;
      end
   end

   // logarithms of numerator and denominator
   pipe_ctl_type                      lg_ctl;
   logic                              lg_valid;
   logic [NLOG_LANES_C-1:0][LW-1:0]   lg_log;
   flags_type                         lg_flags;

   assign lg_ctl.en    = en;
   assign lg_ctl.valid = s3_vld_ff;

   ntc_log2_pipe #(
      .NL (NLOG_LANES_C),
      .XW (XW),
      .LW (LW),
      .SW (FLAGS_W)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lg_ctl),
      .in_x      (s3_x_ff),
      .in_side   (s3_flags_ff),
      .out_valid (lg_valid),
      .out_log   (lg_log),
      .out_side  (lg_flags)
   );

   // stage 4: log difference magnitude and sign
   logic          s4_vld_ff;
   logic [LW-1:0] s4_dmag_ff;
   flags_type     s4_flags_ff;
   // stage 5: scale to natural log, beta divisor
   logic          s5_vld_ff;
   logic [LW-1:0] s5_ln_ff;
   logic [DIVW-1:0] s5_div_ff;
   flags_type     s5_flags_ff;
   // stage 6: divider operands
   logic          s6_vld_ff;
   logic [NLOG_LANES_C-1:0][TW-1:0]   s6_num_ff;
   logic [NLOG_LANES_C-1:0][DIVW-1:0] s6_den_ff;
   flags_type     s6_flags_ff;

   logic            neg_in;
   logic [LW+LN_SHIFT-1:0] ln_prod;

   assign neg_in  = lg_log[LANE_A] < lg_log[LANE_B];
   assign ln_prod = (LW+LN_SHIFT)'(s4_dmag_ff) * (LW+LN_SHIFT)'(LN2_Q24);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= lg_valid;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_dmag_ff  <= neg_in ? (lg_log[LANE_B] - lg_log[LANE_A])
                               : (lg_log[LANE_A] - lg_log[LANE_B]);
         s4_flags_ff <= '{zero_code: lg_flags.zero_code, at_supply: lg_flags.at_supply,
                          neg: neg_in, nonpos: lg_flags.nonpos};

         s5_ln_ff    <= ln_prod[LW+LN_SHIFT-1:LN_SHIFT];
         s5_div_ff   <= DIVW'(CENTI) * DIVW'(b_nz);
         s5_flags_ff <= s4_flags_ff;

         // lane A: rounded ln term, lane B: rounded 2^40 / T0
         s6_num_ff[LANE_A] <= (TW'(s5_ln_ff) << TERM_SHIFT) + TW'(s5_div_ff >> 1);
         s6_den_ff[LANE_A] <= s5_div_ff;
         s6_num_ff[LANE_B] <= TW'(64'd1 << INV_SHIFT) + TW'(t0_nz >> 1);
         s6_den_ff[LANE_B] <= DIVW'(t0_nz);
         s6_flags_ff       <= s5_flags_ff;
      end
   end

   pipe_ctl_type                    da_ctl;
   logic                            da_valid;
   logic [NLOG_LANES_C-1:0][TW-1:0] da_quo;
   flags_type                       da_flags;

   assign da_ctl.en    = en;
   assign da_ctl.valid = s6_vld_ff;

   ntc_div_pipe #(
      .NL (NLOG_LANES_C),
      .NW (TW),
      .DW (DIVW),
      .SW (FLAGS_W)
   ) u_div_term (
      .clock     (clock),
      .reset     (reset),
      .ctl       (da_ctl),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_flags_ff),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_side  (da_flags)
   );

   // stage 7: inverse temperature, stage 8: final divider operands
   logic          s7_vld_ff;
   logic [IW-1:0] s7_inv_ff;
   flags_type     s7_flags_ff;
   logic          s8_vld_ff;
   logic [FW-1:0] s8_num_ff;
   logic [FW-1:0] s8_den_ff;
   flags_type     s8_flags_ff;
   logic [TW:0]   iv;

   assign iv = s7_inv_ff[IW-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= da_valid;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_inv_ff   <= da_flags.neg ? (IW'(da_quo[LANE_B]) - IW'(da_quo[LANE_A]))
                                     : (IW'(da_quo[LANE_B]) + IW'(da_quo[LANE_A]));
         s7_flags_ff <= da_flags;

         s8_num_ff   <= FW'(64'd1 << INV_SHIFT) + FW'(iv >> 1);
         s8_den_ff   <= FW'(iv);
         s8_flags_ff <= '{zero_code: s7_flags_ff.zero_code,
                          at_supply: s7_flags_ff.at_supply,
                          neg:       s7_flags_ff.neg,
                          nonpos:    s7_inv_ff[IW-1] || (s7_inv_ff == '0)};
      end
   end

   pipe_ctl_type    db_ctl;
   logic            db_valid;
   logic [0:0][FW-1:0] db_quo;
   flags_type       db_flags;

   assign db_ctl.en    = en;
   assign db_ctl.valid = s8_vld_ff;

   ntc_div_pipe #(
      .NL (1),
      .NW (FW),
      .DW (FW),
      .SW (FLAGS_W)
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (db_ctl),
      .in_num    (s8_num_ff),
      .in_den    (s8_den_ff),
      .in_side   (s8_flags_ff),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_side  (db_flags)
   );

   // output register: special cases, clamp, offset to Celsius
   logic                out_vld_ff;
   logic [TEMP_W-1:0]   out_temp_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [TEMP_W-1:0]   temp_in;
   logic [STATUS_W-1:0] status_in;
   logic [FW-1:0]       tck;

   assign tck = db_quo[0];

   always_comb begin
      priority if (db_flags.zero_code) begin
         temp_in   = TEMP_W'(TEMP_MIN);
         status_in = ST_ZERO_CODE;
      end else if (db_flags.at_supply) begin
         temp_in   = '0;
         status_in = ST_AT_SUPPLY;
      end else if (db_flags.nonpos || (tck > FW'(TEMP_MAX + CK_OFFSET))) begin
         temp_in   = TEMP_W'(TEMP_MAX);
         status_in = ST_SATURATED;
      end else begin
         temp_in   = tck[TEMP_W-1:0] - TEMP_W'(CK_OFFSET);
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= db_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_temp_ff   <= temp_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_temp_centi_celsius = out_temp_ff;
   assign rsp_status             = out_status_ff;

endmodule

/* rtl/core/ntc_checker.sv */
// Port-level checks for the NTC thermistor linearizer, bound to the top level.
// Depends on ntc_pkg and ntc_thermistor_linearizer.
module ntc_checker import ntc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_temp_centi_celsius,
   input logic [STATUS_W-1:0]      rsp_status
);

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_centi_celsius)
                                  && $stable(rsp_status))
      else $error("result changed while stalled");

   // a stalled output stalls the input side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while pipeline stalled");

   // zero code reads as absolute zero
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO_CODE |->
         rsp_temp_centi_celsius == TEMP_W'(TEMP_MIN))
      else $error("zero code with wrong temperature");

   // voltage at supply reads as zero degrees
   a_at_supply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_AT_SUPPLY |-> rsp_temp_centi_celsius == '0)
      else $error("supply case with nonzero temperature");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ntc_thermistor_linearizer ntc_checker u_ntc_checker (.*);
